### rtl/core/rxs_pkg.sv
package rxs_pkg;

  localparam int MAX_RECORDS = 64;
  localparam int IDX_W       = $clog2(MAX_RECORDS);
  localparam int CNT_W       = $clog2(MAX_RECORDS + 1);

  typedef struct packed {
    logic [63:0] head;
    logic [7:0]  tail;
    logic [15:0] tag;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  function automatic logic key_greater(input rec_t a, input rec_t b);
    key_greater = {a.head, a.tail} > {b.head, b.tail};
  endfunction

endpackage

### rtl/core/rxs_ram.sv
module rxs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/record_exchange_sort_by_key_top.sv
// Record exchange sort by key.
//
// Request channel: a request is taken at a rising edge with start high and
// busy low. Each request carries one record (key_head, key_tail, tag); is_last
// closes the set. Records beyond MAX_RECORDS are dropped and reported on
// overflowed. Non-last requests are taken one per cycle.
//
// After the last request the stored n records are sorted in place in the
// record RAM: one compare per cycle within a pass, with a write-back and a
// reload of the held record between passes, limited by the single read and
// write port of the RAM. Results then stream out one per cycle, n in total,
// each shown for one cycle with result_strobe high; final_item marks the
// last. busy stays high from the last request until the final result is
// issued. Results cannot be held off by the receiver.
//
// Reset (rst, synchronous) empties the set and clears the drop flag; RAM
// contents are not cleared, as only written entries are ever read.
module record_exchange_sort_by_key_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] key_head,
  input  logic [7:0]  key_tail,
  input  logic [15:0] tag,
  input  logic        is_last,
  output logic        result_strobe,
  output logic [63:0] sorted_head,
  output logic [7:0]  sorted_tail,
  output logic [15:0] sorted_tag,
  output logic        final_item,
  output logic        overflowed
);

  import rxs_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RDI   = 3'd1;
  localparam logic [2:0] S_LDI   = 3'd2;
  localparam logic [2:0] S_INNER = 3'd3;
  localparam logic [2:0] S_WRI   = 3'd4;
  localparam logic [2:0] S_EMRD  = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0]       state;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] n;
  logic             drop;
  logic [IDX_W-1:0] i;
  logic [IDX_W-1:0] j;
  logic [IDX_W-1:0] k;
  rec_t             held;

  logic             we;
  logic [IDX_W-1:0] waddr;
  rec_t             wdata;
  logic [IDX_W-1:0] raddr;
  rec_t             rdata;
  logic [REC_W-1:0] rdata_raw;

  logic             has_room;
  logic [CNT_W-1:0] count_next;
  logic             swap;
  logic [CNT_W-1:0] n_less1;

  rxs_ram #(
    .WIDTH(REC_W),
    .DEPTH(MAX_RECORDS)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata_raw)
  );

  assign rdata      = rec_t'(rdata_raw);
  assign busy       = (state != S_IDLE);
  assign has_room   = (count < CNT_W'(MAX_RECORDS));
  assign count_next = has_room ? count + CNT_W'(1) : count;
  assign swap       = key_greater(held, rdata);
  assign n_less1    = n - CNT_W'(1);

  always_comb begin
    we    = 1'b0;
    waddr = i;
    wdata = held;
    raddr = i;
    unique case (state)
      S_IDLE: begin
        if (start && has_room) begin
          we    = 1'b1;
          waddr = count[IDX_W-1:0];
          wdata = '{head: key_head, tail: key_tail, tag: tag};
        end
      end
      S_RDI: begin
        raddr = i;
      end
      S_LDI: begin
        raddr = i + IDX_W'(1);
      end
      S_INNER: begin
        we    = swap;
        waddr = j;
        raddr = j + IDX_W'(1);
      end
      S_WRI: begin
        we    = 1'b1;
        waddr = i;
        raddr = i + IDX_W'(1);
      end
      S_EMRD: begin
        raddr = '0;
      end
      S_EMIT: begin
        raddr = k + IDX_W'(1);
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      drop          <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            count <= count_next;
            if (!has_room) begin
              drop <= 1'b1;
            end
            if (is_last) begin
              state <= (count_next == CNT_W'(1)) ? S_EMRD : S_RDI;
            end
          end
        end
        S_RDI:   state <= S_LDI;
        S_LDI:   state <= S_INNER;
        S_INNER: begin
          if ({1'b0, j} == n_less1) begin
            state <= S_WRI;
          end
        end
        S_WRI: begin
          state <= ({1'b0, i} + CNT_W'(2) == n) ? S_EMRD : S_LDI;
        end
        S_EMRD:  state <= S_EMIT;
        S_EMIT: begin
          result_strobe <= 1'b1;
          if ({1'b0, k} == n_less1) begin
            count <= '0;
            drop  <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        n <= count_next;
        i <= '0;
      end
      S_LDI: begin
        held <= rdata;
        j    <= i + IDX_W'(1);
      end
      S_INNER: begin
        if (swap) begin
          held <= rdata;
        end
        j <= j + IDX_W'(1);
      end
      S_WRI: begin
        i <= i + IDX_W'(1);
      end
      S_EMRD: begin
        k <= '0;
      end
      S_EMIT: begin
        sorted_head <= rdata.head;
        sorted_tail <= rdata.tail;
        sorted_tag  <= rdata.tag;
        final_item  <= ({1'b0, k} == n_less1);
        overflowed  <= drop;
        k           <= k + IDX_W'(1);
      end
      default: begin
      end
    endcase
  end

endmodule
